/* hdl/stke_pkg.sv */
// stke_pkg: shared widths, request and status codes, and the command record
// passed from the front end to the execution unit. No dependencies.
`default_nettype none

package stke_pkg;

   // fixed field widths on the channels
   localparam int REQ_W     = 3;
   localparam int WORD_IN_W = 32;
   localparam int POS_W     = 7;
   localparam int ENTRY_W   = 7;
   localparam int SUM_W     = 38;
   localparam int STAT_W    = 3;

   // defaults for the top-level parameters
   localparam int DEF_DEPTH  = 64;
   localparam int DEF_DATA_W = 32;

   // request type codes as they arrive on the channel
   localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_POP     = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_POS   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NO_MATCH  = 3'd4;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_POP,
      OP_REVERSE,
      OP_REPLACE,
      OP_INSERT,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic signed [WORD_IN_W-1:0]   value;
      logic signed [WORD_IN_W-1:0]   match_value;
      logic        [POS_W-1:0]       position;
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/stke_req_if.sv */
// stke_req_if: request channel, valid/ready handshake with the request fields.
// Depends on stke_pkg for field widths.
`default_nettype none

interface stke_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [stke_pkg::REQ_W-1:0]     req_type;
   logic signed [stke_pkg::WORD_IN_W-1:0] value;
   logic signed [stke_pkg::WORD_IN_W-1:0] match_value;
   logic        [stke_pkg::POS_W-1:0]     position;

   modport source (output valid, output req_type, output value, output match_value,
                   output position, input ready);
   modport sink   (input valid, input req_type, input value, input match_value,
                   input position, output ready);
endinterface

`default_nettype wire

/* hdl/stke_rsp_if.sv */
// stke_rsp_if: response channel, valid/ready handshake with the result fields.
// Depends on stke_pkg for field widths.
`default_nettype none

interface stke_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [stke_pkg::WORD_IN_W-1:0] popped;
   logic        [stke_pkg::ENTRY_W-1:0]   entries;
   logic                                 is_empty;
   logic signed [stke_pkg::SUM_W-1:0]     even_sum;
   logic        [stke_pkg::STAT_W-1:0]    status;

   modport source (output valid, output popped, output entries, output is_empty,
                   output even_sum, output status, input ready);
   modport sink   (input valid, input popped, input entries, input is_empty,
                   input even_sum, input status, output ready);
endinterface

`default_nettype wire

/* hdl/stke_ram.sv */
// stke_ram: generic simple dual-port RAM, one write port and one read port
// with registered read data. No dependencies.
`default_nettype none

module stke_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/stke_front.sv */
// stke_front: accepts requests and classifies the request type into an
// operation code for the command queue. Depends on stke_pkg, stke_req_if.
`default_nettype none

module stke_front (
   stke_req_if.sink              req,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output stke_pkg::cmd_type     cmd
);

   stke_pkg::op_type op;

   // unused codes become a no-op that still gets a response
   always_comb begin
      unique case (req.req_type)
         stke_pkg::REQ_PUSH:    op = stke_pkg::OP_PUSH;
         stke_pkg::REQ_POP:     op = stke_pkg::OP_POP;
         stke_pkg::REQ_REVERSE: op = stke_pkg::OP_REVERSE;
         stke_pkg::REQ_REPLACE: op = stke_pkg::OP_REPLACE;
         stke_pkg::REQ_INSERT:  op = stke_pkg::OP_INSERT;
         stke_pkg::REQ_CLEAR:   op = stke_pkg::OP_CLEAR;
         default:               op = stke_pkg::OP_NOP;
      endcase
   end

   assign cmd.op          = op;
   assign cmd.value       = req.value;
   assign cmd.match_value = req.match_value;
   assign cmd.position    = req.position;
   assign cmd_valid       = req.valid;
   assign req.ready       = cmd_ready;

endmodule

`default_nettype wire

/* hdl/stke_queue.sv */
// stke_queue: two-entry command queue between front end and execution unit.
// Depends on stke_pkg for the command record.
`default_nettype none

module stke_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enq_valid,
   output logic                   enq_ready,
   input  stke_pkg::cmd_type      enq_cmd,
   output logic                   deq_valid,
   input  wire logic              deq_ready,
   output stke_pkg::cmd_type      deq_cmd
);

   stke_pkg::cmd_type slots_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        level_ff, level_in;
   logic              enq_fire, deq_fire;

   assign enq_ready = (level_ff != 2'd2);
   assign deq_valid = (level_ff != 2'd0);
   assign deq_cmd   = slots_ff[rd_ptr_ff];
   assign enq_fire  = enq_valid && enq_ready;
   assign deq_fire  = deq_valid && deq_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ enq_fire;
      rd_ptr_in = rd_ptr_ff ^ deq_fire;
      level_in  = level_ff;
      if (enq_fire && !deq_fire) begin
         level_in = level_ff + 2'd1;
      end else if (deq_fire && !enq_fire) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq_fire) begin
         slots_ff[wr_ptr_ff] <= enq_cmd;
      end
   end

endmodule

`default_nettype wire

/* hdl/stke_back.sv */
// stke_back: execution unit; sequences each command over the word RAM,
// keeps entry count and even sum, and holds the response register.
// Depends on stke_pkg, stke_rsp_if, stke_ram.
`default_nettype none

module stke_back #(
   parameter int DEPTH  = stke_pkg::DEF_DEPTH,
   parameter int DATA_W = stke_pkg::DEF_DATA_W,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   output logic               cmd_ready,
   input  stke_pkg::cmd_type  cmd,
   stke_rsp_if.source         rsp,
   output logic [CNT_W-1:0]   fill_count
);

   localparam int SUM_W  = stke_pkg::SUM_W;
   localparam int OUT_W  = stke_pkg::WORD_IN_W;
   localparam int CMP_W  = (CNT_W > stke_pkg::POS_W) ? CNT_W : stke_pkg::POS_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_POP_RD = 4'd1;
   localparam logic [3:0] ST_RV_RLO = 4'd2;
   localparam logic [3:0] ST_RV_RHI = 4'd3;
   localparam logic [3:0] ST_RV_WLO = 4'd4;
   localparam logic [3:0] ST_RV_WHI = 4'd5;
   localparam logic [3:0] ST_SR_RD  = 4'd6;
   localparam logic [3:0] ST_SR_CMP = 4'd7;
   localparam logic [3:0] ST_IN_RD  = 4'd8;
   localparam logic [3:0] ST_IN_WR  = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   logic [3:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [SUM_W-1:0]                total_ff, total_in;
   logic [stke_pkg::STAT_W-1:0]     status_ff, status_in;
   logic [OUT_W-1:0]                popped_ff, popped_in;
   logic [ADDR_W-1:0]               lo_ff, lo_in;
   logic [ADDR_W-1:0]               hi_ff, hi_in;
   logic [ADDR_W-1:0]               at_ff, at_in;
   logic [DATA_W-1:0]               tmp_ff, tmp_in;
   logic [DATA_W-1:0]               val_ff, val_in;
   logic [DATA_W-1:0]               match_ff, match_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]                rsp_popped_ff, rsp_popped_in;
   logic [stke_pkg::ENTRY_W-1:0]    rsp_entries_ff, rsp_entries_in;
   logic                            rsp_empty_ff, rsp_empty_in;
   logic [SUM_W-1:0]                rsp_sum_ff, rsp_sum_in;
   logic [stke_pkg::STAT_W-1:0]     rsp_status_ff, rsp_status_in;

   logic                            ram_we, ram_re;
   logic [ADDR_W-1:0]               ram_waddr, ram_raddr;
   logic [DATA_W-1:0]               ram_wdata, ram_rdata;

   logic [DATA_W-1:0]               cmd_word;
   logic [CMP_W-1:0]                pos_cmp, cnt_cmp;
   logic                            full, out_free;

   // sum contribution of a stored word: sign-extended when even, else zero
   function automatic logic [SUM_W-1:0] even_ext(input logic [DATA_W-1:0] w);
      even_ext = w[0] ? '0 : SUM_W'($signed(w));
   endfunction

   stke_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign cmd_word  = DATA_W'(cmd.value);
   assign pos_cmp   = CMP_W'(cmd.position);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign cmd_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      at_in     = at_ff;
      tmp_in    = tmp_ff;
      val_in    = val_ff;
      match_in  = match_ff;
      ram_we    = 1'b0;
      ram_waddr = hi_ff;
      ram_wdata = val_ff;
      ram_re    = 1'b0;
      ram_raddr = hi_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_popped_in  = rsp_popped_ff;
      rsp_entries_in = rsp_entries_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_sum_in     = rsp_sum_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               status_in = stke_pkg::STAT_OK;
               popped_in = '0;
               val_in    = cmd_word;
               match_in  = DATA_W'(cmd.match_value);
               state_in  = ST_DONE;
               unique case (cmd.op)
                  stke_pkg::OP_PUSH: begin
                     if (full) begin
                        status_in = stke_pkg::STAT_OVERFLOW;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(count_ff);
                        ram_wdata = cmd_word;
                        count_in  = count_ff + 1'b1;
                        total_in  = total_ff + even_ext(cmd_word);
                     end
                  end
                  stke_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = stke_pkg::STAT_UNDERFLOW;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(count_ff - 1'b1);
                        count_in  = count_ff - 1'b1;
                        state_in  = ST_POP_RD;
                     end
                  end
                  stke_pkg::OP_REVERSE: begin
                     if (count_ff > CNT_W'(1)) begin
                        lo_in    = '0;
                        hi_in    = ADDR_W'(count_ff - 1'b1);
                        state_in = ST_RV_RLO;
                     end
                  end
                  stke_pkg::OP_REPLACE: begin
                     status_in = stke_pkg::STAT_NO_MATCH;
                     if (count_ff != '0) begin
                        hi_in    = ADDR_W'(count_ff - 1'b1);
                        state_in = ST_SR_RD;
                     end
                  end
                  stke_pkg::OP_INSERT: begin
                     if (pos_cmp > cnt_cmp) begin
                        status_in = stke_pkg::STAT_BAD_POS;
                     end else if (full) begin
                        status_in = stke_pkg::STAT_OVERFLOW;
                     end else begin
                        at_in    = ADDR_W'(cnt_cmp - pos_cmp);
                        hi_in    = ADDR_W'(count_ff);
                        state_in = ST_IN_RD;
                     end
                  end
                  stke_pkg::OP_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP_RD: begin
            popped_in = OUT_W'($signed(ram_rdata));
            total_in  = total_ff - even_ext(ram_rdata);
            state_in  = ST_DONE;
         end
         // reverse: swap one pair of entries per pass through RV_RLO, RV_RHI, RV_WLO, RV_WHI
         ST_RV_RLO: begin
            ram_re    = 1'b1;
            ram_raddr = lo_ff;
            state_in  = ST_RV_RHI;
         end
         ST_RV_RHI: begin
            ram_re    = 1'b1;
            ram_raddr = hi_ff;
            tmp_in    = ram_rdata;
            state_in  = ST_RV_WLO;
         end
         ST_RV_WLO: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff;
            ram_wdata = ram_rdata;
            state_in  = ST_RV_WHI;
         end
         ST_RV_WHI: begin
            ram_we    = 1'b1;
            ram_waddr = hi_ff;
            ram_wdata = tmp_ff;
            lo_in     = lo_ff + 1'b1;
            hi_in     = hi_ff - 1'b1;
            state_in  = ((int'(hi_ff) - int'(lo_ff)) > 2) ? ST_RV_RLO : ST_DONE;
         end
         // replace: search downward from the top entry
         ST_SR_RD: begin
            ram_re    = 1'b1;
            ram_raddr = hi_ff;
            state_in  = ST_SR_CMP;
         end
         ST_SR_CMP: begin
            if (ram_rdata == match_ff) begin
               ram_we    = 1'b1;
               ram_waddr = hi_ff;
               ram_wdata = val_ff;
               total_in  = total_ff - even_ext(ram_rdata) + even_ext(val_ff);
               status_in = stke_pkg::STAT_OK;
               state_in  = ST_DONE;
            end else if (hi_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               hi_in    = hi_ff - 1'b1;
               state_in = ST_SR_RD;
            end
         end
         // insert: move entries up one slot from the top down to the gap
         ST_IN_RD: begin
            if (hi_ff == at_ff) begin
               ram_we    = 1'b1;
               ram_waddr = at_ff;
               ram_wdata = val_ff;
               count_in  = count_ff + 1'b1;
               total_in  = total_ff + even_ext(val_ff);
               state_in  = ST_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = hi_ff - 1'b1;
               state_in  = ST_IN_WR;
            end
         end
         ST_IN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = hi_ff;
            ram_wdata = ram_rdata;
            hi_in     = hi_ff - 1'b1;
            state_in  = ST_IN_RD;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_popped_in  = popped_ff;
               rsp_entries_in = stke_pkg::ENTRY_W'(count_ff);
               rsp_empty_in   = (count_ff == '0);
               rsp_sum_in     = total_ff;
               rsp_status_in  = status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      popped_ff      <= popped_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      at_ff          <= at_in;
      tmp_ff         <= tmp_in;
      val_ff         <= val_in;
      match_ff       <= match_in;
      rsp_popped_ff  <= rsp_popped_in;
      rsp_entries_ff <= rsp_entries_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_sum_ff     <= rsp_sum_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.popped   = $signed(rsp_popped_ff);
   assign rsp.entries  = rsp_entries_ff;
   assign rsp.is_empty = rsp_empty_ff;
   assign rsp.even_sum = $signed(rsp_sum_ff);
   assign rsp.status   = rsp_status_ff;
   assign fill_count   = count_ff;

endmodule

`default_nettype wire

/* hdl/stack_engine_top.sv */
// stack_engine_top: bounded LIFO stack engine, front end, command queue and
// execution unit. Depends on stke_pkg, stke_req_if, stke_rsp_if, stke_front,
// stke_queue, stke_back.
//
//   channel    direction  handshake         payload
//   req_chan   in         valid / ready     req_type, value, match_value, position
//   rsp_chan   out        valid / ready     popped, entries, is_empty, even_sum, status
//
// One request is executed at a time by the sequencer in stke_back; the word RAM
// has one read and one write port, which sets the loop costs. Pop reads the top
// word; reverse swaps one pair per pass; replace reads and compares one entry per
// step from the top; insert moves each entry above the insertion point up one slot.
// Synchronous reset clears count, even sum, queue and response valid; the word
// RAM is not cleared. Up to two requests wait in the queue while a response
// stalls in the output register.
`default_nettype none

module stack_engine_top #(
   parameter int DEPTH  = stke_pkg::DEF_DEPTH,
   parameter int DATA_W = stke_pkg::DEF_DATA_W
) (
   input wire logic   clock,
   input wire logic   reset,
   stke_req_if.sink   req_chan,
   stke_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic              fe_valid, fe_ready;
   stke_pkg::cmd_type fe_cmd;
   logic              q_valid, q_ready;
   stke_pkg::cmd_type q_cmd;
   logic [CNT_W-1:0]  fill_count;

   stke_front u_front (
      .req       (req_chan),
      .cmd_valid (fe_valid),
      .cmd_ready (fe_ready),
      .cmd       (fe_cmd)
   );

   stke_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (fe_valid),
      .enq_ready (fe_ready),
      .enq_cmd   (fe_cmd),
      .deq_valid (q_valid),
      .deq_ready (q_ready),
      .deq_cmd   (q_cmd)
   );

   stke_back #(.DEPTH(DEPTH), .DATA_W(DATA_W)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp        (rsp_chan),
      .fill_count (fill_count)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (fill_count == $past(fill_count)) ||
      (fill_count == CNT_W'($past(fill_count) + 1'b1)) ||
      (fill_count == CNT_W'($past(fill_count) - 1'b1)) ||
      (fill_count == '0))
      else $error("entry count moved by more than one");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_empty |-> rsp_chan.entries == '0)
      else $error("empty flag with nonzero entries");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: self-checking bench for stack_engine_top, with a request driver, a
// response monitor and an in-bench stack predictor.
// Uses stke_pkg, stke_req_if and stke_rsp_if.
`timescale 1ns / 100ps

module tb_top;

   localparam int STACK_DEPTH = stke_pkg::DEF_DEPTH;
   localparam int TOTAL_REQS  = 1250;
   localparam int HOLD_AFTER  = 400;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 200;

   // request codes the block ignores
   localparam logic [stke_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [stke_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

   typedef enum logic [1:0] {RX_STREAM, RX_LIGHT, RX_HEAVY} rx_mode_type;

   typedef struct {
      logic        [stke_pkg::REQ_W-1:0]     req_type;
      logic signed [stke_pkg::WORD_IN_W-1:0] value;
      logic signed [stke_pkg::WORD_IN_W-1:0] match_value;
      logic        [stke_pkg::POS_W-1:0]     position;
      bit                                    wait_drain;
   } stack_req_type;

   typedef struct {
      logic signed [stke_pkg::WORD_IN_W-1:0] popped;
      logic        [stke_pkg::ENTRY_W-1:0]   entries;
      logic                                  is_empty;
      logic signed [stke_pkg::SUM_W-1:0]     even_sum;
      logic        [stke_pkg::STAT_W-1:0]    status;
   } stack_rsp_type;

   logic clock;
   logic reset;

   stke_req_if req_if ();
   stke_rsp_if rsp_if ();

   stack_engine_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   stack_req_type req_backlog[$];
   stack_rsp_type rsp_predicted[$];
   int            reqs_taken;
   int            rsps_checked;
   int            mismatch_count;

   // predictor state
   logic signed [stke_pkg::WORD_IN_W-1:0] stk_word [STACK_DEPTH];
   int                                    stk_count;
   logic        [stke_pkg::SUM_W-1:0]     stk_even_sum = '0;

   // stimulus planning state
   int          planned_depth;
   int          planned_reqs;
   logic [31:0] word_pool [16];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [stke_pkg::SUM_W-1:0] widen(
         logic signed [stke_pkg::WORD_IN_W-1:0] w);
      return {{(stke_pkg::SUM_W-stke_pkg::WORD_IN_W){w[stke_pkg::WORD_IN_W-1]}}, w};
   endfunction

   function automatic stack_rsp_type stack_apply(stack_req_type r);
      stack_rsp_type                         res;
      logic signed [stke_pkg::WORD_IN_W-1:0] tmp;
      int                                    i;
      int                                    at;
      res.popped = '0;
      res.status = stke_pkg::STAT_OK;
      case (r.req_type)
         stke_pkg::REQ_PUSH: begin
            if (stk_count >= STACK_DEPTH) begin
               res.status = stke_pkg::STAT_OVERFLOW;
            end else begin
               stk_word[stk_count] = r.value;
               stk_count++;
               if (!r.value[0]) stk_even_sum += widen(r.value);
            end
         end
         stke_pkg::REQ_POP: begin
            if (stk_count == 0) begin
               res.status = stke_pkg::STAT_UNDERFLOW;
            end else begin
               stk_count--;
               res.popped = stk_word[stk_count];
               if (!res.popped[0]) stk_even_sum -= widen(res.popped);
            end
         end
         stke_pkg::REQ_REVERSE: begin
            for (i = 0; i < stk_count / 2; i++) begin
               tmp = stk_word[i];
               stk_word[i] = stk_word[stk_count-1-i];
               stk_word[stk_count-1-i] = tmp;
            end
         end
         stke_pkg::REQ_REPLACE: begin
            res.status = stke_pkg::STAT_NO_MATCH;
            // search starts at the top entry
            for (i = stk_count - 1; i >= 0; i--) begin
               if (stk_word[i] == r.match_value) begin
                  if (!stk_word[i][0]) stk_even_sum -= widen(stk_word[i]);
                  stk_word[i] = r.value;
                  if (!r.value[0]) stk_even_sum += widen(r.value);
                  res.status = stke_pkg::STAT_OK;
                  break;
               end
            end
         end
         stke_pkg::REQ_INSERT: begin
            if (r.position > stk_count) begin
               res.status = stke_pkg::STAT_BAD_POS;
            end else if (stk_count >= STACK_DEPTH) begin
               res.status = stke_pkg::STAT_OVERFLOW;
            end else begin
               at = stk_count - r.position;
               for (i = stk_count; i > at; i--) stk_word[i] = stk_word[i-1];
               stk_word[at] = r.value;
               stk_count++;
               if (!r.value[0]) stk_even_sum += widen(r.value);
            end
         end
         stke_pkg::REQ_CLEAR: begin
            stk_count = 0;
            stk_even_sum = '0;
         end
         default: ;
      endcase
      res.entries = stk_count[stke_pkg::ENTRY_W-1:0];
      res.is_empty = (stk_count == 0);
      res.even_sum = stk_even_sum;
      return res;
   endfunction

   // ---------------- stimulus planning ----------------

   function automatic logic [stke_pkg::POS_W-1:0] rand_pos(int hi);
      return stke_pkg::POS_W'($urandom_range(0, hi));
   endfunction

   task automatic add_req(logic [stke_pkg::REQ_W-1:0] t, logic [31:0] v, logic [31:0] m,
                          logic [stke_pkg::POS_W-1:0] p);
      stack_req_type r;
      r.req_type = t;
      r.value = v;
      r.match_value = m;
      r.position = p;
      r.wait_drain = 1'b0;
      req_backlog.push_back(r);
      case (t)
         stke_pkg::REQ_PUSH:   if (planned_depth < STACK_DEPTH) planned_depth++;
         stke_pkg::REQ_POP:    if (planned_depth > 0) planned_depth--;
         stke_pkg::REQ_INSERT: begin
            if (p <= planned_depth && planned_depth < STACK_DEPTH) planned_depth++;
         end
         stke_pkg::REQ_CLEAR:  planned_depth = 0;
         default: ;
      endcase
      if (t <= stke_pkg::REQ_CLEAR) planned_reqs++;
   endtask

   function automatic logic [31:0] pick_word();
      if ($urandom_range(0, 9) < 6) return word_pool[$urandom_range(0, 15)];
      return $urandom;
   endfunction

   function automatic logic [stke_pkg::POS_W-1:0] pick_position();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         // keep most inserts shallow, each entry moved costs an IN_RD and an IN_WR state
         if (planned_depth > 8 && $urandom_range(0, 3) != 0) return rand_pos(8);
         return rand_pos(planned_depth);
      end
      if (roll < 90) return rand_pos(127);
      return stke_pkg::POS_W'(planned_depth + 1);
   endfunction

   task automatic plan_random_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30)
         add_req(stke_pkg::REQ_PUSH, pick_word(), pick_word(), rand_pos(127));
      else if (roll < 50)
         add_req(stke_pkg::REQ_POP, pick_word(), pick_word(), rand_pos(127));
      else if (roll < 58)
         add_req(stke_pkg::REQ_REVERSE, pick_word(), pick_word(), rand_pos(127));
      else if (roll < 78)
         add_req(stke_pkg::REQ_REPLACE, pick_word(), pick_word(), rand_pos(127));
      else if (roll < 95)
         add_req(stke_pkg::REQ_INSERT, pick_word(), pick_word(), pick_position());
      else if (roll < 97)
         add_req(stke_pkg::REQ_CLEAR, pick_word(), pick_word(), rand_pos(127));
      else
         add_req($urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO, pick_word(),
                 pick_word(), rand_pos(127));
   endtask

   task automatic plan_stimulus();
      int roll;
      int k;
      word_pool[0] = 32'h7fff_ffff;
      word_pool[1] = 32'h8000_0000;
      word_pool[2] = 32'h0000_0000;
      word_pool[3] = 32'hffff_ffff;
      word_pool[4] = 32'h0000_0001;
      word_pool[5] = 32'h0000_0002;
      word_pool[6] = 32'hffff_fffe;
      for (k = 7; k < 16; k++) word_pool[k] = $urandom;

      // directed: empty-stack corners, extreme words, every operation
      add_req(stke_pkg::REQ_POP, 32'h0, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_REVERSE, 32'h0, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_CLEAR, 32'h0, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_REPLACE, 32'h5, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_INSERT, 32'h9, 32'h0, 7'd1);
      add_req(stke_pkg::REQ_INSERT, 32'h7fff_ffff, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_PUSH, 32'h8000_0000, 32'hffff_ffff, 7'd127);
      add_req(stke_pkg::REQ_PUSH, 32'h0, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_PUSH, 32'hffff_ffff, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_PUSH, 32'hffff_fffe, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_PUSH, 32'h2, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_REPLACE, 32'hffff_fffc, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_REPLACE, 32'h1, 32'h0000_3039, 7'd0);
      add_req(stke_pkg::REQ_REVERSE, 32'h0, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_PUSH, 32'h7, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_REVERSE, 32'h0, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_INSERT, 32'h4, 32'h0, 7'd7);
      add_req(stke_pkg::REQ_INSERT, 32'h3, 32'h0, 7'd3);
      add_req(stke_pkg::REQ_INSERT, 32'h6, 32'h0, 7'd127);
      add_req(stke_pkg::REQ_INSERT, 32'h8, 32'h0, 7'd64);
      add_req(REQ_SPARE_LO, 32'hffff_ffff, 32'hffff_ffff, 7'd127);
      add_req(REQ_SPARE_HI, 32'h0, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_POP, 32'h0, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_POP, 32'h0, 32'h0, 7'd0);
      add_req(stke_pkg::REQ_CLEAR, 32'h0, 32'h0, 7'd0);

      while (planned_reqs < TOTAL_REQS) begin
         if ($urandom_range(0, 15) == 0) word_pool[$urandom_range(7, 15)] = $urandom;
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            // fill to the top, then try to go past it
            while (planned_depth < STACK_DEPTH) begin
               if ($urandom_range(0, 3) == 0)
                  add_req(stke_pkg::REQ_INSERT, pick_word(), pick_word(), rand_pos(4));
               else
                  add_req(stke_pkg::REQ_PUSH, pick_word(), pick_word(), rand_pos(127));
            end
            add_req(stke_pkg::REQ_PUSH, pick_word(), pick_word(), rand_pos(127));
            add_req(stke_pkg::REQ_INSERT, pick_word(), pick_word(), rand_pos(STACK_DEPTH));
            add_req(stke_pkg::REQ_INSERT, pick_word(), pick_word(), rand_pos(127));
            add_req(stke_pkg::REQ_REVERSE, pick_word(), pick_word(), rand_pos(127));
         end else if (roll < 18) begin
            while (planned_depth > 0)
               add_req(stke_pkg::REQ_POP, pick_word(), pick_word(), rand_pos(127));
            add_req(stke_pkg::REQ_POP, pick_word(), pick_word(), rand_pos(127));
            add_req(stke_pkg::REQ_REPLACE, pick_word(), pick_word(), rand_pos(127));
         end else if (roll < 20) begin
            add_req(stke_pkg::REQ_CLEAR, pick_word(), pick_word(), rand_pos(127));
         end else begin
            plan_random_op();
         end
      end

      // sender pauses until the block has answered everything
      for (k = 150; k < req_backlog.size(); k += 300) req_backlog[k].wait_drain = 1'b1;
   endtask

   // ---------------- request driver ----------------

   stack_req_type offer;
   int            burst_left;
   int            gap_left;

   always @(posedge clock) begin
      bit took;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.req_type <= '0;
         req_if.value <= '0;
         req_if.match_value <= '0;
         req_if.position <= '0;
         reqs_taken <= 0;
         burst_left = $urandom_range(1, 40);
         gap_left = 0;
      end else begin
         took = req_if.valid && req_if.ready;
         if (took) begin
            rsp_predicted.push_back(stack_apply(offer));
            reqs_taken <= reqs_taken + 1;
         end
         if (!req_if.valid || took) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (req_backlog.size() == 0) begin
               req_if.valid <= 1'b0;
            end else if (req_backlog[0].wait_drain && (took || reqs_taken != rsps_checked)) begin
               req_if.valid <= 1'b0;
            end else begin
               offer = req_backlog.pop_front();
               req_if.valid <= 1'b1;
               req_if.req_type <= offer.req_type;
               req_if.value <= offer.value;
               req_if.match_value <= offer.match_value;
               req_if.position <= offer.position;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // ---------------- response side ----------------

   rx_mode_type rx_mode;
   int          rx_mode_left;
   int          hold_left;
   bit          held_once;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_mode = RX_STREAM;
         rx_mode_left = 0;
         hold_left = 0;
         held_once = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!held_once && reqs_taken >= HOLD_AFTER) begin
         // long back-pressure so the queue fills and the request side stalls
         held_once = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(10, 60);
         end else begin
            rx_mode_left--;
         end
         case (rx_mode)
            RX_STREAM: rsp_if.ready <= 1'b1;
            RX_LIGHT:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default:   rsp_if.ready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      stack_rsp_type want;
      if (reset) begin
         rsps_checked <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         rsps_checked <= rsps_checked + 1;
         if (rsp_predicted.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = rsp_predicted.pop_front();
            if (rsp_if.popped !== want.popped) begin
               $error("popped: expected %0d, got %0d", want.popped, rsp_if.popped);
               mismatch_count++;
            end
            if (rsp_if.entries !== want.entries) begin
               $error("entries: expected %0d, got %0d", want.entries, rsp_if.entries);
               mismatch_count++;
            end
            if (rsp_if.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_if.is_empty);
               mismatch_count++;
            end
            if (rsp_if.even_sum !== want.even_sum) begin
               $error("even_sum: expected %0d, got %0d", want.even_sum, rsp_if.even_sum);
               mismatch_count++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_if.status);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------- run control ----------------

   initial begin
      reset = 1'b1;
      planned_depth = 0;
      planned_reqs = 0;
      plan_stimulus();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // sample between edges so the driver and monitor updates have settled
      while (req_backlog.size() != 0 || req_if.valid || reqs_taken != rsps_checked)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && rsp_predicted.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (rsp_predicted.size() != 0)
            $error("%0d responses never arrived", rsp_predicted.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
